@@ sv/sqbs_pkg.sv @@
// Shared types, codes and microcode program of the bisection square-root core.
// No dependencies; used by sqbs_sequencer, sqbs_datapath and the top level.
package sqbs_pkg;

    // Width and reset value of the tolerance register
    localparam int unsigned TOL_W = 16;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

    // Step counter
    localparam int unsigned PC_W = 3;
    typedef logic [PC_W-1:0] t_pc;

    // Datapath operations
    localparam logic [2:0] OP_NOP    = 3'd0;
    localparam logic [2:0] OP_LOAD   = 3'd1;
    localparam logic [2:0] OP_MID    = 3'd2;
    localparam logic [2:0] OP_MUL0   = 3'd3;
    localparam logic [2:0] OP_MUL1   = 3'd4;
    localparam logic [2:0] OP_MUL2   = 3'd5;
    localparam logic [2:0] OP_UPDATE = 3'd6;

    // Sequencer branch conditions
    localparam logic [2:0] COND_NEXT     = 3'd0;
    localparam logic [2:0] COND_ALWAYS   = 3'd1;
    localparam logic [2:0] COND_STOP     = 3'd2;
    localparam logic [2:0] COND_WAIT_IN  = 3'd3;
    localparam logic [2:0] COND_WAIT_OUT = 3'd4;

    // Program addresses
    localparam t_pc STEP_IDLE   = 3'd0;
    localparam t_pc STEP_MID    = 3'd1;
    localparam t_pc STEP_MUL0   = 3'd2;
    localparam t_pc STEP_MUL1   = 3'd3;
    localparam t_pc STEP_MUL2   = 3'd4;
    localparam t_pc STEP_UPDATE = 3'd5;
    localparam t_pc STEP_EMIT   = 3'd6;

    // One microcode word
    typedef struct packed {
        logic [2:0] op;
        logic [2:0] cond;
        t_pc        target;
        logic       in_rdy;
        logic       emit;
    } t_ctrl;

    // Status flags the sequencer branches on
    typedef struct packed {
        logic in_go;
        logic out_free;
        logic stop;
    } t_stat;

    // Microcode ROM
    function automatic t_ctrl sqbs_ucode(input t_pc pc);
        t_ctrl w;
        w = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_IDLE, in_rdy: 1'b0, emit: 1'b0};
        unique case (pc)
            STEP_IDLE: begin
                w = '{op: OP_LOAD, cond: COND_WAIT_IN, target: STEP_MID,
                      in_rdy: 1'b1, emit: 1'b0};
            end
            STEP_MID: begin
                w = '{op: OP_MID, cond: COND_STOP, target: STEP_EMIT,
                      in_rdy: 1'b0, emit: 1'b0};
            end
            STEP_MUL0: begin
                w = '{op: OP_MUL0, cond: COND_NEXT, target: STEP_IDLE,
                      in_rdy: 1'b0, emit: 1'b0};
            end
            STEP_MUL1: begin
                w = '{op: OP_MUL1, cond: COND_NEXT, target: STEP_IDLE,
                      in_rdy: 1'b0, emit: 1'b0};
            end
            STEP_MUL2: begin
                w = '{op: OP_MUL2, cond: COND_NEXT, target: STEP_IDLE,
                      in_rdy: 1'b0, emit: 1'b0};
            end
            STEP_UPDATE: begin
                w = '{op: OP_UPDATE, cond: COND_ALWAYS, target: STEP_MID,
                      in_rdy: 1'b0, emit: 1'b0};
            end
            STEP_EMIT: begin
                w = '{op: OP_NOP, cond: COND_WAIT_OUT, target: STEP_IDLE,
                      in_rdy: 1'b0, emit: 1'b1};
            end
            default: begin
                w = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_IDLE,
                      in_rdy: 1'b0, emit: 1'b0};
            end
        endcase
        return w;
    endfunction

endpackage

@@ sv/sqbs_sequencer.sv @@
// Step counter and microcode lookup with conditional jumps.
// Depends on sqbs_pkg (control word, status, program).
module sqbs_sequencer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sqbs_pkg::t_stat i_stat,
    output sqbs_pkg::t_ctrl o_ctrl
);

    sqbs_pkg::t_pc   r_pc;
    sqbs_pkg::t_pc   n_pc;
    sqbs_pkg::t_ctrl w_ctrl;

    // Fetch the current control word
    assign w_ctrl = sqbs_pkg::sqbs_ucode(r_pc);
    assign o_ctrl = w_ctrl;

    // Pick the next step
    always_comb begin
        n_pc = r_pc + 1'b1;
        unique case (w_ctrl.cond)
            sqbs_pkg::COND_NEXT:     n_pc = r_pc + 1'b1;
            sqbs_pkg::COND_ALWAYS:   n_pc = w_ctrl.target;
            sqbs_pkg::COND_STOP:     n_pc = i_stat.stop ? w_ctrl.target : r_pc + 1'b1;
            sqbs_pkg::COND_WAIT_IN:  n_pc = i_stat.in_go ? w_ctrl.target : r_pc;
            sqbs_pkg::COND_WAIT_OUT: n_pc = i_stat.out_free ? w_ctrl.target : r_pc;
            default:                 n_pc = sqbs_pkg::STEP_IDLE;
        endcase
    end

    // Advance the step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= sqbs_pkg::STEP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

@@ sv/sqbs_datapath.sv @@
// Bisection datapath: bounds, midpoint, shared half-width multiplier, compare.
// Depends on sqbs_pkg (operation codes, tolerance width).
module sqbs_datapath #(
    parameter int WIDTH     = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic [2:0]                i_op,
    input  logic                      i_load,
    input  logic signed [WIDTH-1:0]   i_x_value,
    input  logic [sqbs_pkg::TOL_W-1:0] i_tol,
    output logic                      o_stop,
    output logic [WIDTH-2:0]          o_root,
    output logic                      o_invalid
);

    // Value width covers the operand magnitude and the constant one
    localparam int VW = (WIDTH - 1 > FRAC_BITS + 1) ? WIDTH - 1 : FRAC_BITS + 1;
    localparam int H  = (VW + 1) / 2;
    localparam int MW = 2 * H;
    localparam int AW = 2 * VW;
    localparam int CW = (VW > sqbs_pkg::TOL_W) ? VW : sqbs_pkg::TOL_W;
    localparam logic [VW-1:0] ONE = {{(VW-1){1'b0}}, 1'b1} << FRAC_BITS;

    logic [VW-1:0] r_raw;
    logic [VW-1:0] r_lower;
    logic [VW-1:0] r_upper;
    logic [VW-1:0] r_mid;
    logic [AW-1:0] r_acc;
    logic          r_special;
    logic          r_invalid;

    logic [VW-1:0] w_mag;
    logic [VW-1:0] w_half;
    logic [MW-1:0] w_mid_p;
    logic [H-1:0]  w_lo;
    logic [H-1:0]  w_hi;
    logic [H-1:0]  w_ma;
    logic [H-1:0]  w_mb;
    logic [MW-1:0] w_prod;
    logic [AW-1:0] w_xs;
    logic          w_exceeds;

    // Operand magnitude; sign bit handled separately
    assign w_mag = VW'(i_x_value[WIDTH-2:0]);

    // Half the interval: also the midpoint minus the lower bound
    assign w_half = (r_upper - r_lower) >> 1;
    assign o_stop = r_special || (CW'(w_half) <= CW'(i_tol));

    // Shared multiplier: low*low, high*low, high*high
    assign w_mid_p = MW'(r_mid);
    assign w_lo    = w_mid_p[H-1:0];
    assign w_hi    = w_mid_p[MW-1:H];
    assign w_ma    = (i_op == sqbs_pkg::OP_MUL2) ? w_hi : w_lo;
    assign w_mb    = (i_op == sqbs_pkg::OP_MUL0) ? w_lo : w_hi;
    assign w_prod  = w_ma * w_mb;

    // Compare the square with the operand scaled by the fraction bits
    assign w_xs      = AW'(r_raw) << FRAC_BITS;
    assign w_exceeds = r_acc > w_xs;

    // Execute one micro-operation
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            sqbs_pkg::OP_LOAD: begin
                if (i_load) begin
                    r_raw     <= w_mag;
                    r_lower   <= '0;
                    r_upper   <= (w_mag >= ONE) ? w_mag : ONE;
                    r_special <= i_x_value[WIDTH-1] || (i_x_value == '0);
                    r_invalid <= i_x_value[WIDTH-1];
                end
            end
            sqbs_pkg::OP_MID: begin
                r_mid <= r_lower + w_half;
            end
            sqbs_pkg::OP_MUL0: begin
                r_acc <= AW'(w_prod);
            end
            sqbs_pkg::OP_MUL1: begin
                r_acc <= r_acc + (AW'(w_prod) << (H + 1));
            end
            sqbs_pkg::OP_MUL2: begin
                r_acc <= r_acc + (AW'(w_prod) << MW);
            end
            sqbs_pkg::OP_UPDATE: begin
                if (w_exceeds) begin
                    r_upper <= r_mid;
                end else begin
                    r_lower <= r_mid;
                end
            end
            default: begin
            end
        endcase
    end

    // Special operands give zero
    assign o_root    = r_special ? '0 : r_mid[WIDTH-2:0];
    assign o_invalid = r_invalid;

endmodule

@@ sv/square_root_bisection_core.sv @@
// Fixed-point square root by bisection, microcoded control over a small datapath.
// Each bisection step runs the midpoint, three passes of the shared half-width multiplier
// and the bound update; zero and negative operands go from the midpoint step straight to
// the result. A new operand is taken only in the idle step, after the last result is emitted.
// The next item is taken while a result waits. Reset: synchronous, active low;
// tolerance returns to 1, no result pending.
module square_root_bisection_core #(
    parameter int WIDTH     = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic [sqbs_pkg::TOL_W-1:0] i_cfg_data,
    output logic                       o_cfg_ready,
    input  logic                       i_x_valid,
    input  logic signed [WIDTH-1:0]    i_x_value,
    output logic                       o_x_ready,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output logic [WIDTH-2:0]           o_root,
    output logic                       o_invalid
);

    logic                       r_live;
    logic [sqbs_pkg::TOL_W-1:0] r_tol;
    logic                       r_res_valid;
    logic [WIDTH-2:0]           r_root;
    logic                       r_invalid;

    sqbs_pkg::t_ctrl  w_ctrl;
    sqbs_pkg::t_stat  w_stat;
    logic             w_x_fire;
    logic             w_out_free;
    logic             w_emit;
    logic             w_stop;
    logic [WIDTH-2:0] w_root;
    logic             w_invalid;

    // Hold off both input channels until out of reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
        end else begin
            r_live <= 1'b1;
        end
    end

    // Tolerance register
    assign o_cfg_ready = r_live;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= sqbs_pkg::TOL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_tol <= i_cfg_data;
        end
    end

    // Handshake status for the sequencer
    assign o_x_ready  = w_ctrl.in_rdy && r_live;
    assign w_x_fire   = i_x_valid && o_x_ready;
    assign w_out_free = !r_res_valid || i_res_ready;
    assign w_emit     = w_ctrl.emit && w_out_free;
    assign w_stat     = '{in_go: w_x_fire, out_free: w_out_free, stop: w_stop};

    sqbs_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    sqbs_datapath #(
        .WIDTH     (WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_op      (w_ctrl.op),
        .i_load    (w_x_fire),
        .i_x_value (i_x_value),
        .i_tol     (r_tol),
        .o_stop    (w_stop),
        .o_root    (w_root),
        .o_invalid (w_invalid)
    );

    // Result register: hold the beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_emit) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_root    <= w_root;
            r_invalid <= w_invalid;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_root      = r_root;
    assign o_invalid   = r_invalid;

    // A negative operand always yields a zero root
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_invalid |-> o_root == '0)
        else $error("invalid result with nonzero root");

    // An accepted operand goes straight to the midpoint step
    a_load_then_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_x_fire |=> w_ctrl.op == sqbs_pkg::OP_MID)
        else $error("operand accepted but sequencer did not start");

    // A new result appears only from the emit step
    a_emit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res_valid) |-> $past(w_ctrl.emit))
        else $error("result valid raised outside the emit step");

endmodule

@@ tb/sqbs_result_checker.sv @@
// Result checker for the bisection square-root core: watches the config, operand and
// result channels, predicts each root and compares it with what the core returns.
// Depends on sqbs_pkg for the tolerance register width and reset value.
module sqbs_result_checker #(
    parameter int WIDTH     = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [sqbs_pkg::TOL_W-1:0] i_cfg_data,
    input  logic                       i_x_valid,
    input  logic                       i_x_ready,
    input  logic signed [WIDTH-1:0]    i_x_value,
    input  logic                       i_res_valid,
    input  logic                       i_res_ready,
    input  logic [WIDTH-2:0]           i_root,
    input  logic                       i_invalid,
    output int                         o_mismatches,
    output int                         o_outstanding
);

    localparam int PRINT_CAP = 60;

    typedef struct packed {
        logic [WIDTH-1:0] operand;
        logic [WIDTH-2:0] root;
        logic             invalid;
    } t_root_beat;

    t_root_beat                 expected_roots[$];
    logic [sqbs_pkg::TOL_W-1:0] tolerance = sqbs_pkg::TOL_RESET;
    int                         mismatch_count = 0;

    // Bisect [0, max(x, 1.0)] until the midpoint is within tolerance of the lower bound
    function automatic t_root_beat predict_root(input logic [WIDTH-1:0] x,
                                                input logic [sqbs_pkg::TOL_W-1:0] tol);
        t_root_beat   beat;
        logic [63:0]  one_fx;
        logic [63:0]  raw;
        logic [63:0]  lo;
        logic [63:0]  hi;
        logic [63:0]  mid;
        logic [127:0] wide_mid;
        logic [127:0] limit;
        one_fx       = 64'd1 << FRAC_BITS;
        beat.operand = x;
        beat.root    = '0;
        beat.invalid = 1'b0;
        if (x[WIDTH-1]) begin
            // negative operand stands in for NaN
            beat.invalid = 1'b1;
        end else if (x != '0) begin
            raw   = 64'(x);
            limit = 128'(raw) << FRAC_BITS;
            lo    = '0;
            hi    = (raw >= one_fx) ? raw : one_fx;
            mid   = lo + ((hi - lo) >> 1);
            while (mid - lo > 64'(tol)) begin
                wide_mid = 128'(mid);
                if (wide_mid * wide_mid > limit) begin
                    hi = mid;
                end else begin
                    lo = mid;
                end
                mid = lo + ((hi - lo) >> 1);
            end
            beat.root = mid[WIDTH-2:0];
        end
        return beat;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP) begin
            $display("mismatch @%0t: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    // Track config beats, queue predictions on operand beats, compare result beats
    always @(posedge i_clk) begin : watch_beats
        t_root_beat want;
        if (!i_rst_n) begin
            tolerance = sqbs_pkg::TOL_RESET;
            expected_roots.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                tolerance = i_cfg_data;
            end
            if (i_x_valid && i_x_ready) begin
                expected_roots.push_back(predict_root(i_x_value, tolerance));
            end
            if (i_res_valid && i_res_ready) begin
                if (expected_roots.size() == 0) begin
                    report_mismatch($sformatf("result beat root=%h invalid=%b with none pending",
                                              i_root, i_invalid));
                end else begin
                    want = expected_roots.pop_front();
                    if (i_root !== want.root) begin
                        report_mismatch($sformatf("x=%h root got %h want %h",
                                                  want.operand, i_root, want.root));
                    end
                    if (i_invalid !== want.invalid) begin
                        report_mismatch($sformatf("x=%h invalid got %b want %b",
                                                  want.operand, i_invalid, want.invalid));
                    end
                end
            end
        end
        o_outstanding <= expected_roots.size();
        o_mismatches  <= mismatch_count;
    end

endmodule

@@ tb/testbench.sv @@
// Top of the bisection square-root core testbench: clock, reset, operand and config
// stimulus, result back-pressure and the final verdict.
// Depends on sqbs_pkg, square_root_bisection_core and sqbs_result_checker.
module testbench;

    localparam int WIDTH         = 32;
    localparam int FRAC_BITS     = 16;
    localparam int LIMIT_CYCLES  = 2_000_000;
    localparam int HOLD_CYCLES   = 800;
    localparam int SETTLE_CYCLES = 5 * WIDTH + 40;
    localparam int NUM_PHASES    = 7;
    localparam int NUM_CORNERS   = 22;

    localparam logic [WIDTH-1:0] CORNER_OPERANDS [NUM_CORNERS] = '{
        32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_4000,
        32'h0000_8000, 32'h0000_FFFF, 32'h0001_0000, 32'h0001_0001,
        32'h0002_0000, 32'h0004_0000, 32'h0009_0000, 32'h0064_0000,
        32'h5555_5555, 32'h7FFF_0000, 32'h7FFF_FFFE, 32'h7FFF_FFFF,
        32'h8000_0000, 32'h8000_0001, 32'hAAAA_AAAA, 32'hFFFF_0000,
        32'hFFFF_FFFF, 32'h0000_0100
    };

    typedef enum logic [1:0] {
        DRAIN_FULL,
        DRAIN_BUSY,
        DRAIN_SPARSE
    } t_drain_mode;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic [sqbs_pkg::TOL_W-1:0] cfg_data  = '0;
    logic                       cfg_ready;
    logic                       x_valid   = 1'b0;
    logic signed [WIDTH-1:0]    x_value   = '0;
    logic                       x_ready;
    logic                       res_valid;
    logic                       res_ready = 1'b0;
    logic [WIDTH-2:0]           root;
    logic                       invalid;
    int                         mismatches;
    int                         pending_roots;
    int                         hold_requests = 0;
    int                         burst_left    = 0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    square_root_bisection_core #(
        .WIDTH     (WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .i_cfg_data  (cfg_data),
        .o_cfg_ready (cfg_ready),
        .i_x_valid   (x_valid),
        .i_x_value   (x_value),
        .o_x_ready   (x_ready),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_root      (root),
        .o_invalid   (invalid)
    );

    sqbs_result_checker #(
        .WIDTH     (WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .i_x_valid     (x_valid),
        .i_x_ready     (x_ready),
        .i_x_value     (x_value),
        .i_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .i_root        (root),
        .i_invalid     (invalid),
        .o_mismatches  (mismatches),
        .o_outstanding (pending_roots)
    );

    // Abort a hung run
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Stall the result side: random modes, plus a long hold-off when asked
    initial begin : result_sink
        t_drain_mode mode;
        int          mode_left;
        int          holds_done;
        mode       = DRAIN_FULL;
        mode_left  = 0;
        holds_done = 0;
        forever begin
            @(posedge clk);
            if (hold_requests > holds_done) begin
                holds_done++;
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (mode_left == 0) begin
                mode      = t_drain_mode'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            case (mode)
                DRAIN_FULL:   res_ready <= 1'b1;
                DRAIN_BUSY:   res_ready <= ($urandom_range(0, 3) != 0);
                default:      res_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Spread operands over sign, zero, sub-unity, exact squares and all magnitudes
    function automatic logic [WIDTH-1:0] pick_operand();
        int unsigned      sel;
        int unsigned      k;
        logic [WIDTH-1:0] v;
        sel = $urandom_range(0, 99);
        if (sel < 10) begin
            v = {1'b1, 31'($urandom())};
        end else if (sel < 14) begin
            v = '0;
        end else if (sel < 24) begin
            v = $urandom_range(1, 65535);
        end else if (sel < 32) begin
            k = $urandom_range(1, 46340);
            v = k * k;
        end else if (sel < 40) begin
            v = 32'h7FFF_FFFF - $urandom_range(0, 4095);
        end else begin
            v = {1'b0, 31'($urandom())} >> $urandom_range(0, 30);
        end
        return v;
    endfunction

    // Present one operand beat and hold it until taken; valid stays high afterwards
    task automatic push_operand(input logic [WIDTH-1:0] v);
        x_valid <= 1'b1;
        x_value <= v;
        do @(posedge clk); while (!x_ready);
    endtask

    // Send in bursts with random gaps between them
    task automatic offer_operand(input logic [WIDTH-1:0] v);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
            if (gap != 0) begin
                x_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        push_operand(v);
    endtask

    // Keep offering back to back while the result side holds off
    task automatic flood_during_hold(input int n);
        hold_requests++;
        repeat (n) push_operand(pick_operand());
        burst_left = 0;
    endtask

    // Drop valid and wait until every predicted root has come back
    task automatic drain_results();
        x_valid   <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending_roots != 0);
    endtask

    task automatic write_tolerance(input logic [sqbs_pkg::TOL_W-1:0] tol);
        cfg_valid <= 1'b1;
        cfg_data  <= tol;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [sqbs_pkg::TOL_W-1:0] tol_plan [NUM_PHASES];
        int                         item_plan [NUM_PHASES];
        tol_plan  = '{16'd1, 16'd0, 16'hFFFF, 16'h8000,
                      sqbs_pkg::TOL_W'($urandom_range(2, 16)),
                      sqbs_pkg::TOL_W'($urandom()), 16'd1};
        item_plan = '{350, 300, 250, 200, 350, 200, 200};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corner operands at the reset tolerance
        foreach (CORNER_OPERANDS[i]) begin
            offer_operand(CORNER_OPERANDS[i]);
        end

        // Random operands under each tolerance setting
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            write_tolerance(tol_plan[p]);
            for (int i = 0; i < item_plan[p]; i++) begin
                if ((p == 0 || p == 4) && i == 40) begin
                    flood_during_hold(12);
                end
                if (p == 2 && i == item_plan[p] / 2) begin
                    drain_results();
                end
                offer_operand(pick_operand());
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ square_root_bisection_core.f @@
sv/sqbs_pkg.sv
sv/sqbs_sequencer.sv
sv/sqbs_datapath.sv
sv/square_root_bisection_core.sv
tb/sqbs_result_checker.sv
tb/testbench.sv
